[rtl/sdc_pkg.sv]
// Shared constants, types and a helper function of the serial day calendar decoder.
package sdc_pkg;

   localparam logic [21:0] SPAN_FIRST = 22'd2415386;  // 1901-01-01
   localparam logic [21:0] SPAN_LAST  = 22'd2488069;  // 2099-12-31
   localparam logic [16:0] Y4_DAYS    = 17'd1461;
   localparam logic [15:0] RECIP_Y4   = 16'd45933;    // floor(2^26 / 1461)
   localparam logic [13:0] RECIP_7    = 14'd9362;     // floor(2^16 / 7)
   localparam logic [11:0] RECIP_7S   = 12'd2341;     // ceil(2^14 / 7), small operands
   localparam logic [11:0] BASE_YEAR  = 12'd1901;
   localparam logic [2:0]  DOW_SUN    = 3'd6;

   typedef struct packed {
      logic        oos;
      logic [11:0] year;
      logic [8:0]  doy;
      logic        leap;
      logic        prev_leap;
      logic [2:0]  dow;        // 0 is Monday
   } split_type;

   typedef struct packed {
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] year_number;
      logic [8:0]  day_of_year;
      logic [5:0]  iso_week;
      logic        summer_time;
      logic        out_of_span;
   } result_type;

   // zero-based day of year at which a month starts, common year
   function automatic logic [8:0] month_start(input logic [3:0] m);
      logic [8:0] s;
      case (m)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

[rtl/sdc_if.sv]
// Valid/ready channel interfaces for day numbers and decoded dates.
interface sdc_req_if;
   logic        valid;
   logic        ready;
   logic [21:0] serial_day;
   modport source (output valid, output serial_day, input ready);
   modport sink (input valid, input serial_day, output ready);
endinterface

interface sdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  day_of_month;
   logic [3:0]  month_number;
   logic [11:0] year_number;
   logic [8:0]  day_of_year;
   logic [5:0]  iso_week;
   logic        summer_time;
   logic        out_of_span;
   modport source (output valid, output day_of_month, output month_number,
                   output year_number, output day_of_year, output iso_week,
                   output summer_time, output out_of_span, input ready);
   modport sink (input valid, input day_of_month, input month_number,
                 input year_number, input day_of_year, input iso_week,
                 input summer_time, input out_of_span, output ready);
endinterface

[rtl/sdc_divide.sv]
// Front pipeline: span check, four-year cycle split, year, day of year and weekday.
module sdc_divide (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [21:0]         in_day,
   output logic                out_valid,
   input  logic                out_ready,
   output sdc_pkg::split_type  out_data
);
   import sdc_pkg::*;

   logic        v1_ff, v2_ff, v3_ff;
   logic        rdy1, rdy2, rdy3;

   // stage 1
   logic        oos1_ff, oos1_in;
   logic [16:0] t1_ff, t1_in;
   logic [16:0] tp1_ff, tp1_in;
   logic [32:0] prod1_ff, prod1_in;
   logic [30:0] p7_ff, p7_in;
   // stage 2
   logic        oos2_ff;
   logic [11:0] r2_ff, r2_in;
   logic [6:0]  q2_ff;
   logic [2:0]  dow2_ff, dow2_in;
   logic [14:0] q7;
   logic [3:0]  rm7;
   // stage 3
   split_type   s3_ff, s3_in;
   logic [10:0] r3;
   logic [5:0]  q3;
   logic [1:0]  yc;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      oos1_in  = (in_day < SPAN_FIRST) || (in_day > SPAN_LAST);
      t1_in    = oos1_in ? 17'd0 : 17'(in_day - SPAN_FIRST);
      tp1_in   = t1_in + 17'd1;
      prod1_in = 33'(t1_in) * 33'(RECIP_Y4);
      p7_in    = 31'(tp1_in) * 31'(RECIP_7);
   end

   always_comb begin
      r2_in   = 12'(t1_ff - 17'(17'(prod1_ff[32:26]) * Y4_DAYS));
      q7      = p7_ff[30:16];
      rm7     = 4'(tp1_ff - 17'(17'(q7) * 17'd7));
      dow2_in = (rm7 >= 4'd7) ? 3'(rm7 - 4'd7) : rm7[2:0];
   end

   always_comb begin
      if (r2_ff >= 12'(Y4_DAYS)) begin
         r3 = 11'(r2_ff - 12'(Y4_DAYS));
         q3 = 6'(q2_ff + 7'd1);
      end else begin
         r3 = r2_ff[10:0];
         q3 = q2_ff[5:0];
      end
      if (r3 >= 11'd1095)     yc = 2'd3;
      else if (r3 >= 11'd730) yc = 2'd2;
      else if (r3 >= 11'd365) yc = 2'd1;
      else                    yc = 2'd0;
      s3_in.oos       = oos2_ff;
      s3_in.doy       = 9'(r3 - 11'(11'(yc) * 11'd365));
      s3_in.year      = BASE_YEAR + {4'd0, q3, 2'b00} + 12'(yc);
      s3_in.leap      = (yc == 2'd3);
      s3_in.prev_leap = (yc == 2'd0);
      s3_in.dow       = dow2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
      if (rdy1) begin
         oos1_ff  <= oos1_in;
         t1_ff    <= t1_in;
         tp1_ff   <= tp1_in;
         prod1_ff <= prod1_in;
         p7_ff    <= p7_in;
      end
      if (rdy2) begin
         oos2_ff <= oos1_ff;
         r2_ff   <= r2_in;
         q2_ff   <= prod1_ff[32:26];
         dow2_ff <= dow2_in;
      end
      if (rdy3) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

[rtl/sdc_calendar.sv]
// Back pipeline: month and day, weekday of January 1, ISO week and summer time.
module sdc_calendar (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sdc_pkg::split_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sdc_pkg::result_type out_data
);
   import sdc_pkg::*;

   logic        v4_ff, v5_ff, v6_ff;
   logic        rdy4, rdy5, rdy6;

   // stage 4
   split_type   s4_ff;
   logic [3:0]  mon4_ff, mon4_in;
   logic [5:0]  qd4_ff, qd4_in;
   logic [5:0]  wk4_ff, wk4_in;
   logic [8:0]  wnum;
   logic [8:0]  thr;
   // stage 5
   split_type   s5_ff;
   logic [3:0]  mon5_ff;
   logic [4:0]  day5_ff, day5_in;
   logic [2:0]  j15_ff, j15_in;
   logic [5:0]  wk5_ff;
   logic [2:0]  dm7;
   logic [8:0]  mstart;
   // stage 6
   result_type  r6_ff, r6_in;
   logic        long_cur, long_prev;
   logic [3:0]  pj_sum, m_sum, o_sum;
   logic [2:0]  pj, dow_m, dow_o, back_m, back_o;
   logic [8:0]  mar_doy, oct_doy;
   logic [5:0]  week;

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_comb begin
      mon4_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         thr = month_start(4'(k)) + ((k >= 3) ? 9'(in_data.leap) : 9'd0);
         if (in_data.doy >= thr) mon4_in = mon4_in + 4'd1;
      end
      qd4_in = 6'((21'(in_data.doy) * 21'(RECIP_7S)) >> 14);
      wnum   = in_data.doy + 9'd10 - 9'(in_data.dow);
      wk4_in = 6'((21'(wnum) * 21'(RECIP_7S)) >> 14);
   end

   always_comb begin
      mstart  = month_start(mon4_ff) + ((mon4_ff >= 4'd3) ? 9'(s4_ff.leap) : 9'd0);
      day5_in = 5'(s4_ff.doy - mstart + 9'd1);
      dm7     = 3'(s4_ff.doy - 9'(9'(qd4_ff) * 9'd7));
      // weekday of January 1
      j15_in  = (s4_ff.dow >= dm7) ? 3'(s4_ff.dow - dm7) : 3'(s4_ff.dow + 3'd7 - dm7);
   end

   always_comb begin
      long_cur  = (j15_ff == 3'd3) || (s5_ff.leap && j15_ff == 3'd2);
      pj_sum    = 4'(j15_ff) + 4'd6 - 4'(s5_ff.prev_leap);
      pj        = (pj_sum >= 4'd7) ? 3'(pj_sum - 4'd7) : pj_sum[2:0];
      long_prev = (pj == 3'd3) || (s5_ff.prev_leap && pj == 3'd2);
      if (wk5_ff == 6'd0)                    week = long_prev ? 6'd53 : 6'd52;
      else if (wk5_ff == 6'd53 && !long_cur) week = 6'd1;
      else                                   week = wk5_ff;
      // last Sundays: step back from March 31 and October 31
      m_sum  = 4'(j15_ff) + 4'd5 + 4'(s5_ff.leap);
      dow_m  = (m_sum >= 4'd7) ? 3'(m_sum - 4'd7) : m_sum[2:0];
      o_sum  = 4'(j15_ff) + 4'd2 + 4'(s5_ff.leap);
      dow_o  = (o_sum >= 4'd7) ? 3'(o_sum - 4'd7) : o_sum[2:0];
      back_m = (dow_m == DOW_SUN) ? 3'd0 : dow_m + 3'd1;
      back_o = (dow_o == DOW_SUN) ? 3'd0 : dow_o + 3'd1;
      mar_doy = 9'd89 + 9'(s5_ff.leap) - 9'(back_m);
      oct_doy = 9'd303 + 9'(s5_ff.leap) - 9'(back_o);
      r6_in = '0;
      r6_in.out_of_span = s5_ff.oos;
      if (!s5_ff.oos) begin
         r6_in.day_of_month = day5_ff;
         r6_in.month_number = mon5_ff;
         r6_in.year_number  = s5_ff.year;
         r6_in.day_of_year  = s5_ff.doy;
         r6_in.iso_week     = week;
         r6_in.summer_time  = (s5_ff.doy >= mar_doy) && (s5_ff.doy < oct_doy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
      if (rdy4) begin
         s4_ff   <= in_data;
         mon4_ff <= mon4_in;
         qd4_ff  <= qd4_in;
         wk4_ff  <= wk4_in;
      end
      if (rdy5) begin
         s5_ff   <= s4_ff;
         mon5_ff <= mon4_ff;
         day5_ff <= day5_in;
         j15_ff  <= j15_in;
         wk5_ff  <= wk4_ff;
      end
      if (rdy6) r6_ff <= r6_in;
   end

   assign out_valid = v6_ff;
   assign out_data  = r6_ff;

endmodule

[rtl/serial_day_calendar_decode_unit.sv]
// Top level of the Julian day number to Gregorian date and ISO week decoder.
//
//   channel   dir   payload                                       beat
//   req_bus   in    serial_day                                    valid & ready
//   rsp_bus   out   date, day of year, week, summer, span flag    valid & ready
//
// Six register stages: three in the cycle split, three in the calendar back end.
// One beat per cycle sustained while rsp_bus.ready stays high.
// Each stage holds its beat while the next is full, so stalls lose nothing.
// Synchronous reset empties the pipeline; no other state.
module serial_day_calendar_decode_unit (
   input logic        clock,
   input logic        reset,
   sdc_req_if.sink    req_bus,
   sdc_rsp_if.source  rsp_bus
);
   import sdc_pkg::*;

   logic       mid_valid, mid_ready;
   split_type  mid_data;
   result_type res;

   sdc_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_day    (req_bus.serial_day),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   sdc_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (res)
   );

   assign rsp_bus.day_of_month = res.day_of_month;
   assign rsp_bus.month_number = res.month_number;
   assign rsp_bus.year_number  = res.year_number;
   assign rsp_bus.day_of_year  = res.day_of_year;
   assign rsp_bus.iso_week     = res.iso_week;
   assign rsp_bus.summer_time  = res.summer_time;
   assign rsp_bus.out_of_span  = res.out_of_span;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   a_oos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.out_of_span) |->
         (rsp_bus.day_of_month == 5'd0 && rsp_bus.iso_week == 6'd0 &&
          rsp_bus.year_number == 12'd0 && !rsp_bus.summer_time))
      else $error("out of span beat carries date fields");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.out_of_span) |->
         (rsp_bus.month_number >= 4'd1 && rsp_bus.month_number <= 4'd12 &&
          rsp_bus.day_of_month >= 5'd1 && rsp_bus.iso_week >= 6'd1 &&
          rsp_bus.iso_week <= 6'd53 && rsp_bus.day_of_year <= 9'd365))
      else $error("decoded date out of range");

   a_summer_months: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.summer_time) |->
         (rsp_bus.month_number >= 4'd3 && rsp_bus.month_number <= 4'd10))
      else $error("summer time outside March to October");

endmodule
